@@ hdl/vps_pkg.sv @@
// shared types, constants and fixed-point helpers for the verlet particle block
// used by vps_mem, vps_sqrt, vps_divider and the top level
package vps_pkg;

  localparam int DEF_MAX_PARTICLES = 256;
  localparam int DEF_FRAC_BITS     = 20;

  localparam int POS_W      = 32;
  localparam int MASS_W     = 16;
  localparam int RAD_W      = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // square root radicand width (even) and divider widths
  localparam int SQRT_RAD_W = 52;
  localparam int DIV_DVD_W  = 50;
  localparam int DIV_DSR_W  = 26;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOUND_LOW_X  = 3'd0,
    REG_BOUND_LOW_Y  = 3'd1,
    REG_BOUND_HIGH_X = 3'd2,
    REG_BOUND_HIGH_Y = 3'd3,
    REG_COUNT        = 3'd4,
    REG_DAMPING      = 3'd5,
    REG_GRAVITY      = 3'd6,
    REG_PUSH_GAIN    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
  } pos_t;

  typedef struct packed {
    logic [MASS_W-1:0] mass;
    logic [RAD_W-1:0]  radius;
  } attr_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] res;
    if (v > 36'sd2147483647) begin
      res = 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // push a coordinate back inside [lo, hi] keeping the radius clear of the wall
  function automatic logic signed [31:0] clamp_wall(input logic signed [31:0] p,
                                                    input logic [RAD_W-1:0] r,
                                                    input logic signed [31:0] lo,
                                                    input logic signed [31:0] hi);
    logic signed [35:0] pe;
    logic signed [35:0] re;
    logic signed [35:0] loe;
    logic signed [35:0] hie;
    logic signed [31:0] res;
    pe  = 36'(p);
    re  = 36'($signed({1'b0, r}));
    loe = 36'(lo);
    hie = 36'(hi);
    if (pe + re > hie) begin
      res = sat32(hie - re);
    end else if (pe - re < loe) begin
      res = sat32(loe + re);
    end else begin
      res = p;
    end
    return res;
  endfunction

endpackage

@@ hdl/vps_mem.sv @@
// particle slot memories: position words and mass/radius words
// one write port, two registered read ports; uses vps_pkg types
module vps_mem #(
  parameter int DEPTH = vps_pkg::DEF_MAX_PARTICLES,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  input  logic             pos_we,
  input  logic             attr_we,
  input  logic [AW-1:0]    wr_addr,
  input  vps_pkg::pos_t    wr_pos,
  input  vps_pkg::attr_t   wr_attr,
  output vps_pkg::pos_t    rd_pos_a,
  output vps_pkg::pos_t    rd_pos_b,
  output vps_pkg::attr_t   rd_attr_a,
  output vps_pkg::attr_t   rd_attr_b
);

  vps_pkg::pos_t  pos_mem  [DEPTH];
  vps_pkg::attr_t attr_mem [DEPTH];

  vps_pkg::pos_t  rd_pos_a_r;
  vps_pkg::pos_t  rd_pos_b_r;
  vps_pkg::attr_t rd_attr_a_r;
  vps_pkg::attr_t rd_attr_b_r;

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[wr_addr] <= wr_pos;
    end
    if (attr_we) begin
      attr_mem[wr_addr] <= wr_attr;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_pos_a_r  <= pos_mem[rd_addr_a];
      rd_pos_b_r  <= pos_mem[rd_addr_b];
      rd_attr_a_r <= attr_mem[rd_addr_a];
      rd_attr_b_r <= attr_mem[rd_addr_b];
    end
  end

  assign rd_pos_a  = rd_pos_a_r;
  assign rd_pos_b  = rd_pos_b_r;
  assign rd_attr_a = rd_attr_a_r;
  assign rd_attr_b = rd_attr_b_r;

endmodule

@@ hdl/vps_sqrt.sv @@
// iterative integer square root, one result bit per cycle
// depends on vps_pkg for the default radicand width
module vps_sqrt #(
  parameter int RW = vps_pkg::SQRT_RAD_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [RW-1:0]   radicand,
  output logic            done,
  output logic [RW/2-1:0] root
);

  localparam int QW   = RW / 2;
  localparam int REMW = QW + 4;
  localparam int CNTW = $clog2(QW + 1);

  logic [CNTW-1:0] cnt_r;
  logic            done_r;
  logic [RW-1:0]   rad_r;
  logic [QW-1:0]   root_r;
  logic [REMW-1:0] rem_r;

  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            ge;

  always_comb begin
    rem_sh = {rem_r[REMW-3:0], rad_r[RW-1:RW-2]};
    trial  = {{(REMW-QW-2){1'b0}}, root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= CNTW'(QW);
        rad_r  <= radicand;
        root_r <= '0;
        rem_r  <= '0;
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - CNTW'(1);
        rem_r  <= ge ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[QW-2:0], ge};
        rad_r  <= {rad_r[RW-3:0], 2'b00};
        if (cnt_r == CNTW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (cnt_r == '0)) else $error("sqrt started while busy");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (cnt_r == '0)) else $error("sqrt done while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("sqrt done held");

endmodule

@@ hdl/vps_divider.sv @@
// iterative restoring divider, one quotient bit per cycle
// shared by the collision path; depends on vps_pkg for default widths
module vps_divider #(
  parameter int DVW = vps_pkg::DIV_DVD_W,
  parameter int DSW = vps_pkg::DIV_DSR_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DVW-1:0] dividend,
  input  logic [DSW-1:0] divisor,
  output logic           done,
  output logic [DVW-1:0] quotient
);

  localparam int CNTW = $clog2(DVW + 1);

  logic [CNTW-1:0] cnt_r;
  logic            done_r;
  logic [DSW-1:0]  rem_r;
  logic [DSW-1:0]  dsr_r;
  logic [DVW-1:0]  quo_r;

  logic [DSW:0] rem_sh;
  logic [DSW:0] diff;
  logic         ge;

  always_comb begin
    rem_sh = {rem_r, quo_r[DVW-1]};
    diff   = rem_sh - {1'b0, dsr_r};
    ge     = rem_sh >= {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNTW'(DVW);
        rem_r <= '0;
        quo_r <= dividend;
        dsr_r <= divisor;
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNTW'(1);
        rem_r <= ge ? diff[DSW-1:0] : rem_sh[DSW-1:0];
        quo_r <= {quo_r[DVW-2:0], ge};
        if (cnt_r == CNTW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (cnt_r == '0)) else $error("divider started while busy");

  a_nonzero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (dsr_r != '0)) else $error("divide by zero");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (cnt_r == '0)) else $error("divider done while busy");

endmodule

@@ hdl/verlet_particle_collision_step_top.sv @@
// verlet particle block: a load or op 3 registers its result word when accepted; a read
// registers the slot memory word, then the result word; a step moves every particle,
// walks every pair (a root for pairs past the quick check, six divides if they overlap)
// and clamps each to the walls; one word at a time; the slot memory port and the shared divider set the rate
// reset (sync, active low) restores config defaults and idles the sequencer;
// slot memories are not cleared
module verlet_particle_collision_step_top #(
  parameter int MAX_PARTICLES = vps_pkg::DEF_MAX_PARTICLES,
  parameter int FRAC_BITS     = vps_pkg::DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_operation,
  input  logic [7:0]          in_slot,
  input  logic signed [31:0]  in_x,
  input  logic signed [31:0]  in_y,
  input  logic signed [31:0]  in_prev_x,
  input  logic signed [31:0]  in_prev_y,
  input  logic [15:0]         in_mass,
  input  logic [23:0]         in_radius,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_slot,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_prev_x,
  output logic signed [31:0]  out_prev_y,
  output logic                out_step_done,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  localparam logic signed [63:0] HX_FULL = 64'sd800 <<< FRAC_BITS;
  localparam logic signed [63:0] HY_FULL = 64'sd600 <<< FRAC_BITS;
  localparam logic signed [31:0] HIGH_X_RST =
    (HX_FULL > 64'sd2147483647) ? 32'sh7FFFFFFF : HX_FULL[31:0];
  localparam logic signed [31:0] HIGH_Y_RST =
    (HY_FULL > 64'sd2147483647) ? 32'sh7FFFFFFF : HY_FULL[31:0];

  typedef enum logic [4:0] {
    S_IDLE, S_RD_WAIT,
    S_MV_RD, S_MV_CALC, S_MV_WR,
    S_COL_RD, S_COL_CHK, S_COL_SQ1, S_COL_SQ2, S_COL_SQS, S_COL_SQW,
    S_COL_T, S_COL_MUL, S_COL_DIVS, S_COL_DIVW, S_COL_WI, S_COL_WJ, S_COL_NEXT,
    S_CL_RD, S_CL_WR, S_FIN
  } state_t;

  typedef enum logic [2:0] {
    JOB_AI, JOB_AJ, JOB_MXI, JOB_MYI, JOB_MXJ, JOB_MYJ
  } job_t;

  state_t state_r;

  // configuration
  logic signed [31:0] lo_x_r, lo_y_r, hi_x_r, hi_y_r;
  logic [8:0]         count_r;
  logic [15:0]        damp_r, grav_r, gain_r;

  // sequencer
  logic [CW-1:0] n_r, i_r, j_r;
  job_t          k_r;
  logic          slot_ok_r;

  // result word
  logic               out_valid_r;
  logic [7:0]         out_slot_r;
  logic signed [31:0] out_x_r, out_y_r, out_px_r, out_py_r;
  logic               out_done_r;

  // datapath registers
  logic signed [49:0] mvx_r, mvy_r;
  logic [24:0]        adx_r, ady_r, rs_r, o_r;
  logic               sx_r, sy_r;
  logic [15:0]        ma_r, mb_r;
  logic [16:0]        msum_r;
  logic [49:0]        sq_r;
  logic [50:0]        rad_r;
  logic [25:0]        dist_r;
  logic [40:0]        t_r;
  logic [49:0]        dvd_r;
  logic [25:0]        dvs_r;
  logic [24:0]        ai_r, aj_r, mxi_r, myi_r, mxj_r, myj_r;

  // memory
  logic           mem_rd_en, pos_we, attr_we;
  logic [AW-1:0]  rd_addr_a, rd_addr_b, wr_addr;
  vps_pkg::pos_t  wr_pos, pa, pb;
  vps_pkg::attr_t wr_attr, aa, ab;

  vps_mem #(.DEPTH(MAX_PARTICLES), .AW(AW)) u_mem (
    .clk       (clk),
    .rd_en     (mem_rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .pos_we    (pos_we),
    .attr_we   (attr_we),
    .wr_addr   (wr_addr),
    .wr_pos    (wr_pos),
    .wr_attr   (wr_attr),
    .rd_pos_a  (pa),
    .rd_pos_b  (pb),
    .rd_attr_a (aa),
    .rd_attr_b (ab)
  );

  logic        sqrt_done;
  logic [25:0] sqrt_root;

  vps_sqrt #(.RW(vps_pkg::SQRT_RAD_W)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_COL_SQS),
    .radicand ({1'b0, rad_r}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  logic        div_done;
  logic [49:0] div_q;

  vps_divider #(.DVW(vps_pkg::DIV_DVD_W), .DSW(vps_pkg::DIV_DSR_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == S_COL_DIVS),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  logic          accept;
  logic          slot_ok;
  logic [AW-1:0] slot_addr;
  logic [CW-1:0] n_cfg;

  assign in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign slot_ok   = int'(in_slot) < MAX_PARTICLES;
  assign slot_addr = AW'(in_slot);
  assign n_cfg     = (int'(count_r) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(count_r);

  // motion phase
  logic signed [32:0] dmx, dmy;
  logic signed [49:0] mulx, muly;
  logic signed [33:0] vx, vy;
  logic signed [35:0] sumx, sumy;
  vps_pkg::pos_t      mv_pos;

  always_comb begin
    dmx  = 33'($signed(pa.x)) - 33'($signed(pa.px));
    dmy  = 33'($signed(pa.y)) - 33'($signed(pa.py));
    mulx = dmx * $signed({1'b0, damp_r});
    muly = dmy * $signed({1'b0, damp_r});
    vx   = mvx_r[49:16];
    vy   = mvy_r[49:16];
    sumx = 36'($signed(pa.x)) + 36'(vx);
    sumy = 36'($signed(pa.y)) + 36'(vy) - 36'($signed({1'b0, grav_r}));
    mv_pos.x  = vps_pkg::sat32(sumx);
    mv_pos.y  = vps_pkg::sat32(sumy);
    mv_pos.px = pa.x;
    mv_pos.py = pa.y;
  end

  // pair check
  logic signed [32:0] dx, dy;
  logic [32:0]        adx, ady;
  logic [24:0]        rs;
  logic [16:0]        msum;
  logic               far, skip;
  logic [49:0]        sqy;
  logic [40:0]        t_c;

  always_comb begin
    dx   = 33'($signed(pb.x)) - 33'($signed(pa.x));
    dy   = 33'($signed(pb.y)) - 33'($signed(pa.y));
    adx  = dx[32] ? 33'(-dx) : 33'(dx);
    ady  = dy[32] ? 33'(-dy) : 33'(dy);
    rs   = 25'(aa.radius) + 25'(ab.radius);
    msum = 17'(aa.mass) + 17'(ab.mass);
    far  = (adx[32:25] != '0) || (ady[32:25] != '0);
    // the root is never below either component, so those pairs cannot overlap
    skip = far || (adx >= 33'(rs)) || (ady >= 33'(rs)) || (adx == '0 && ady == '0) ||
           (msum == '0);
    sqy  = ady_r * ady_r;
    t_c  = o_r * gain_r;
  end

  // shared divider jobs: push amounts, then the four moves
  logic [56:0] prodm;
  logic [49:0] prodc;
  logic [15:0] mass_sel;
  logic [24:0] c_sel, a_sel;

  always_comb begin
    mass_sel = (k_r == JOB_AI) ? mb_r : ma_r;
    c_sel    = (k_r == JOB_MXI || k_r == JOB_MXJ) ? adx_r : ady_r;
    a_sel    = (k_r == JOB_MXI || k_r == JOB_MYI) ? ai_r : aj_r;
    prodm    = t_r * mass_sel;
    prodc    = c_sel * a_sel;
  end

  logic signed [26:0] mvxi, mvyi, mvxj, mvyj;
  vps_pkg::pos_t      col_pos_i, col_pos_j, cl_pos;

  always_comb begin
    mvxi = sx_r ? -$signed({2'b00, mxi_r}) : $signed({2'b00, mxi_r});
    mvyi = sy_r ? -$signed({2'b00, myi_r}) : $signed({2'b00, myi_r});
    mvxj = sx_r ? -$signed({2'b00, mxj_r}) : $signed({2'b00, mxj_r});
    mvyj = sy_r ? -$signed({2'b00, myj_r}) : $signed({2'b00, myj_r});
    col_pos_i.x  = vps_pkg::sat32(36'($signed(pa.x)) - 36'(mvxi));
    col_pos_i.y  = vps_pkg::sat32(36'($signed(pa.y)) - 36'(mvyi));
    col_pos_i.px = pa.px;
    col_pos_i.py = pa.py;
    col_pos_j.x  = vps_pkg::sat32(36'($signed(pb.x)) + 36'(mvxj));
    col_pos_j.y  = vps_pkg::sat32(36'($signed(pb.y)) + 36'(mvyj));
    col_pos_j.px = pb.px;
    col_pos_j.py = pb.py;
    cl_pos.x  = vps_pkg::clamp_wall(pa.x, aa.radius, lo_x_r, hi_x_r);
    cl_pos.y  = vps_pkg::clamp_wall(pa.y, aa.radius, lo_y_r, hi_y_r);
    cl_pos.px = pa.px;
    cl_pos.py = pa.py;
  end

  // memory port control
  always_comb begin
    mem_rd_en = 1'b0;
    pos_we    = 1'b0;
    attr_we   = 1'b0;
    rd_addr_a = i_r[AW-1:0];
    rd_addr_b = j_r[AW-1:0];
    wr_addr   = i_r[AW-1:0];
    wr_pos    = mv_pos;
    wr_attr   = '{mass: in_mass, radius: in_radius};
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_operation == vps_pkg::OP_LOAD && slot_ok) begin
          pos_we  = 1'b1;
          attr_we = 1'b1;
          wr_addr = slot_addr;
          wr_pos  = '{x: in_x, y: in_y, px: in_prev_x, py: in_prev_y};
        end else if (accept && in_operation == vps_pkg::OP_READ) begin
          mem_rd_en = 1'b1;
          rd_addr_a = slot_addr;
        end
      end
      S_MV_RD, S_COL_RD, S_CL_RD: begin
        mem_rd_en = 1'b1;
      end
      S_MV_WR: begin
        pos_we = 1'b1;
      end
      S_COL_WI: begin
        pos_we = 1'b1;
        wr_pos = col_pos_i;
      end
      S_COL_WJ: begin
        pos_we  = 1'b1;
        wr_addr = j_r[AW-1:0];
        wr_pos  = col_pos_j;
      end
      S_CL_WR: begin
        pos_we = 1'b1;
        wr_pos = cl_pos;
      end
      default: begin
      end
    endcase
  end

  logic pairs_done, row_end;
  assign row_end    = (j_r == n_r - CW'(1));
  assign pairs_done = row_end && (i_r == n_r - CW'(2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lo_x_r      <= '0;
      lo_y_r      <= '0;
      hi_x_r      <= HIGH_X_RST;
      hi_y_r      <= HIGH_Y_RST;
      count_r     <= '0;
      damp_r      <= 16'd65470;
      grav_r      <= 16'd52;
      gain_r      <= 16'd26214;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= JOB_AI;
    end else begin
      if (cfg_wr_en) begin
        unique case (vps_pkg::cfg_reg_t'(cfg_index))
          vps_pkg::REG_BOUND_LOW_X:  lo_x_r  <= cfg_data;
          vps_pkg::REG_BOUND_LOW_Y:  lo_y_r  <= cfg_data;
          vps_pkg::REG_BOUND_HIGH_X: hi_x_r  <= cfg_data;
          vps_pkg::REG_BOUND_HIGH_Y: hi_y_r  <= cfg_data;
          vps_pkg::REG_COUNT:        count_r <= cfg_data[8:0];
          vps_pkg::REG_DAMPING:      damp_r  <= cfg_data[15:0];
          vps_pkg::REG_GRAVITY:      grav_r  <= cfg_data[15:0];
          vps_pkg::REG_PUSH_GAIN:    gain_r  <= cfg_data[15:0];
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            out_slot_r <= in_slot;
            out_x_r    <= '0;
            out_y_r    <= '0;
            out_px_r   <= '0;
            out_py_r   <= '0;
            out_done_r <= 1'b0;
            slot_ok_r  <= slot_ok;
            unique case (vps_pkg::op_t'(in_operation))
              vps_pkg::OP_LOAD, vps_pkg::OP_NONE: begin
                out_valid_r <= 1'b1;
              end
              vps_pkg::OP_READ: begin
                state_r <= S_RD_WAIT;
              end
              vps_pkg::OP_STEP: begin
                n_r     <= n_cfg;
                i_r     <= '0;
                state_r <= (n_cfg == '0) ? S_FIN : S_MV_RD;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          out_valid_r <= 1'b1;
          if (slot_ok_r) begin
            out_x_r  <= pa.x;
            out_y_r  <= pa.y;
            out_px_r <= pa.px;
            out_py_r <= pa.py;
          end
          state_r <= S_IDLE;
        end
        S_MV_RD: begin
          state_r <= S_MV_CALC;
        end
        S_MV_CALC: begin
          mvx_r   <= mulx;
          mvy_r   <= muly;
          state_r <= S_MV_WR;
        end
        S_MV_WR: begin
          if (i_r == n_r - CW'(1)) begin
            i_r     <= '0;
            j_r     <= CW'(1);
            state_r <= (n_r < CW'(2)) ? S_CL_RD : S_COL_RD;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_MV_RD;
          end
        end
        S_COL_RD: begin
          state_r <= S_COL_CHK;
        end
        S_COL_CHK: begin
          if (skip) begin
            state_r <= S_COL_NEXT;
          end else begin
            adx_r   <= adx[24:0];
            ady_r   <= ady[24:0];
            sx_r    <= dx[32];
            sy_r    <= dy[32];
            rs_r    <= rs;
            ma_r    <= aa.mass;
            mb_r    <= ab.mass;
            msum_r  <= msum;
            state_r <= S_COL_SQ1;
          end
        end
        S_COL_SQ1: begin
          sq_r    <= adx_r * adx_r;
          state_r <= S_COL_SQ2;
        end
        S_COL_SQ2: begin
          rad_r   <= 51'(sq_r) + 51'(sqy);
          state_r <= S_COL_SQS;
        end
        S_COL_SQS: begin
          state_r <= S_COL_SQW;
        end
        S_COL_SQW: begin
          if (sqrt_done) begin
            if (sqrt_root == '0 || sqrt_root >= {1'b0, rs_r}) begin
              state_r <= S_COL_NEXT;
            end else begin
              dist_r  <= sqrt_root;
              o_r     <= rs_r - sqrt_root[24:0];
              state_r <= S_COL_T;
            end
          end
        end
        S_COL_T: begin
          t_r     <= t_c;
          k_r     <= JOB_AI;
          state_r <= S_COL_MUL;
        end
        S_COL_MUL: begin
          if (k_r == JOB_AI || k_r == JOB_AJ) begin
            dvd_r <= 50'(prodm[56:16]);
            dvs_r <= 26'(msum_r);
          end else begin
            dvd_r <= prodc;
            dvs_r <= dist_r;
          end
          state_r <= S_COL_DIVS;
        end
        S_COL_DIVS: begin
          state_r <= S_COL_DIVW;
        end
        S_COL_DIVW: begin
          if (div_done) begin
            case (k_r)
              JOB_AI:  ai_r  <= div_q[24:0];
              JOB_AJ:  aj_r  <= div_q[24:0];
              JOB_MXI: mxi_r <= div_q[24:0];
              JOB_MYI: myi_r <= div_q[24:0];
              JOB_MXJ: mxj_r <= div_q[24:0];
              default: myj_r <= div_q[24:0];
            endcase
            if (k_r == JOB_MYJ) begin
              state_r <= S_COL_WI;
            end else begin
              k_r     <= job_t'(k_r + 3'd1);
              state_r <= S_COL_MUL;
            end
          end
        end
        S_COL_WI: begin
          state_r <= S_COL_WJ;
        end
        S_COL_WJ: begin
          state_r <= S_COL_NEXT;
        end
        S_COL_NEXT: begin
          if (pairs_done) begin
            i_r     <= '0;
            state_r <= S_CL_RD;
          end else if (row_end) begin
            i_r     <= i_r + CW'(1);
            j_r     <= i_r + CW'(2);
            state_r <= S_COL_RD;
          end else begin
            j_r     <= j_r + CW'(1);
            state_r <= S_COL_RD;
          end
        end
        S_CL_RD: begin
          state_r <= S_CL_WR;
        end
        S_CL_WR: begin
          if (i_r == n_r - CW'(1)) begin
            state_r <= S_FIN;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_CL_RD;
          end
        end
        S_FIN: begin
          out_valid_r <= 1'b1;
          out_done_r  <= 1'b1;
          state_r     <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_slot      = out_slot_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_prev_x    = out_px_r;
  assign out_prev_y    = out_py_r;
  assign out_step_done = out_done_r;

  // a busy sequencer never holds an untaken result word
  a_busy_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r) else $error("result pending while busy");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COL_RD) |-> ((j_r > i_r) && (j_r < n_r)))
    else $error("pair indices out of order");

  a_div_operand: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COL_DIVS) |-> (dvs_r != '0)) else $error("zero divisor issued");

  a_write_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COL_WI) |=> (state_r == S_COL_WJ) && pos_we)
    else $error("pair write-back split");

endmodule

@@ test/testbench.sv @@
// testbench for the verlet particle block: drives loads, steps and reads,
// predicts every result word in place, and checks the result channel
// depends on vps_pkg and verlet_particle_collision_step_top
`timescale 1ns / 1ps

module testbench;

  typedef struct {
    logic [7:0]  slot;
    logic [31:0] x, y, px, py;
    logic        done;
  } result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = vps_pkg::OP_NONE;
  logic [7:0]  in_slot = '0;
  logic signed [31:0] in_x = '0, in_y = '0, in_prev_x = '0, in_prev_y = '0;
  logic [15:0] in_mass = '0;
  logic [23:0] in_radius = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_slot;
  logic signed [31:0] out_x, out_y, out_prev_x, out_prev_y;
  logic        out_step_done;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // mirror of the block's state
  longint      px_mem[256], py_mem[256], ox_mem[256], oy_mem[256];
  longint      mass_mem[256], rad_mem[256];
  longint      lo_x, lo_y, hi_x, hi_y;
  int unsigned count_reg, damp_reg, grav_reg, gain_reg;

  result_t     expected_words[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  always #6 clk = ~clk;

  verlet_particle_collision_step_top i_dut (.*);

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic longint push_dist(longint c, longint unsigned a, longint unsigned d);
    longint unsigned mag = (c < 0) ? -c : c;
    longint m = longint'(mag * a / d);
    return (c < 0) ? -m : m;
  endfunction

  function automatic longint wall(longint p, longint r, longint lo, longint hi);
    if (p + r > hi) return sat(hi - r);
    if (p - r < lo) return sat(lo + r);
    return p;
  endfunction

  task automatic advance_particles();
    int n = (count_reg > 256) ? 256 : count_reg;
    longint vx, vy, dx, dy;
    longint unsigned pair_dist, rs, msum, ov, ai, aj;
    for (int i = 0; i < n; i++) begin
      vx = ((px_mem[i] - ox_mem[i]) * longint'(damp_reg)) >>> 16;
      vy = ((py_mem[i] - oy_mem[i]) * longint'(damp_reg)) >>> 16;
      ox_mem[i] = px_mem[i];
      oy_mem[i] = py_mem[i];
      px_mem[i] = sat(px_mem[i] + vx);
      py_mem[i] = sat(py_mem[i] + vy - longint'(grav_reg));
    end
    for (int i = 0; i < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        dx = px_mem[j] - px_mem[i];
        dy = py_mem[j] - py_mem[i];
        // far pairs are skipped outright
        if (dx >= (64'sd1 << 25) || dx <= -(64'sd1 << 25) ||
            dy >= (64'sd1 << 25) || dy <= -(64'sd1 << 25)) continue;
        pair_dist = int_sqrt(longint'(dx * dx + dy * dy));
        rs = rad_mem[i] + rad_mem[j];
        if (pair_dist == 0 || pair_dist >= rs) continue;
        msum = mass_mem[i] + mass_mem[j];
        if (msum == 0) continue;
        ov = rs - pair_dist;
        ai = ov * gain_reg * longint'(mass_mem[j]) / (msum << 16);
        aj = ov * gain_reg * longint'(mass_mem[i]) / (msum << 16);
        px_mem[i] = sat(px_mem[i] - push_dist(dx, ai, pair_dist));
        py_mem[i] = sat(py_mem[i] - push_dist(dy, ai, pair_dist));
        px_mem[j] = sat(px_mem[j] + push_dist(dx, aj, pair_dist));
        py_mem[j] = sat(py_mem[j] + push_dist(dy, aj, pair_dist));
      end
    end
    for (int i = 0; i < n; i++) begin
      px_mem[i] = wall(px_mem[i], rad_mem[i], lo_x, hi_x);
      py_mem[i] = wall(py_mem[i], rad_mem[i], lo_y, hi_y);
    end
  endtask

  task automatic predict_word(vps_pkg::op_t op, logic [7:0] slot, logic [31:0] x,
                              logic [31:0] y, logic [31:0] ox, logic [31:0] oy,
                              logic [15:0] m, logic [23:0] r);
    result_t w = '{slot: slot, x: 0, y: 0, px: 0, py: 0, done: 0};
    case (op)
      vps_pkg::OP_LOAD: begin
        px_mem[slot] = sx32(x);
        py_mem[slot] = sx32(y);
        ox_mem[slot] = sx32(ox);
        oy_mem[slot] = sx32(oy);
        mass_mem[slot] = m;
        rad_mem[slot] = r;
      end
      vps_pkg::OP_STEP: begin
        advance_particles();
        w.done = 1'b1;
      end
      vps_pkg::OP_READ: begin
        w.x = px_mem[slot][31:0];
        w.y = py_mem[slot][31:0];
        w.px = ox_mem[slot][31:0];
        w.py = oy_mem[slot][31:0];
      end
      default: ;
    endcase
    expected_words.push_back(w);
  endtask

  task automatic send_word(vps_pkg::op_t op, logic [7:0] slot, logic [31:0] x = 0,
                           logic [31:0] y = 0, logic [31:0] ox = 0, logic [31:0] oy = 0,
                           logic [15:0] m = 0, logic [23:0] r = 0);
    int gap = 0;
    if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_slot <= slot;
    in_x <= x;
    in_y <= y;
    in_prev_x <= ox;
    in_prev_y <= oy;
    in_mass <= m;
    in_radius <= r;
    do @(posedge clk); while (!in_ready);
    predict_word(op, slot, x, y, ox, oy, m, r);
  endtask

  task automatic drain();
    int guard = 0;
    in_valid <= 1'b0;
    while (expected_words.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(vps_pkg::cfg_reg_t idx, logic [31:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      vps_pkg::REG_BOUND_LOW_X:  lo_x = sx32(value);
      vps_pkg::REG_BOUND_LOW_Y:  lo_y = sx32(value);
      vps_pkg::REG_BOUND_HIGH_X: hi_x = sx32(value);
      vps_pkg::REG_BOUND_HIGH_Y: hi_y = sx32(value);
      vps_pkg::REG_COUNT:        count_reg = value[8:0];
      vps_pkg::REG_DAMPING:      damp_reg = value[15:0];
      vps_pkg::REG_GRAVITY:      grav_reg = value[15:0];
      vps_pkg::REG_PUSH_GAIN:    gain_reg = value[15:0];
    endcase
  endtask

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
    error_count++;
  endtask

  always @(posedge clk) begin
    result_t w;
    if (rst_n && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        report("unexpected word", {24'd0, out_slot}, 32'd0);
      end else begin
        w = expected_words.pop_front();
        if (out_slot !== w.slot) report("slot", out_slot, w.slot);
        if (out_x !== w.x) report("x", out_x, w.x);
        if (out_y !== w.y) report("y", out_y, w.y);
        if (out_prev_x !== w.px) report("prev_x", out_prev_x, w.px);
        if (out_prev_y !== w.py) report("prev_y", out_prev_y, w.py);
        if (out_step_done !== w.done) report("step_done", out_step_done, w.done);
      end
    end
  end

  // a particle near the cluster center so that neighbors overlap
  task automatic load_near(logic [7:0] slot);
    logic [31:0] x = 32'd104857600 + $urandom_range(4194304) - 2097152;
    logic [31:0] y = 32'd104857600 + $urandom_range(4194304) - 2097152;
    send_word(vps_pkg::OP_LOAD, slot, x, y, x + $urandom_range(32768) - 16384,
              y + $urandom_range(32768) - 16384, $urandom_range(1, 65535),
              $urandom_range(524288, 2097152));
  endtask

  task automatic test_directed();
    for (int s = 0; s < 6; s++) load_near(s);
    // two particles at the same place, a zero-mass pair, field extremes
    send_word(vps_pkg::OP_LOAD, 6, 32'd104857600, 32'd104857600, 0, 0, 0, 24'hFFFFFF);
    send_word(vps_pkg::OP_LOAD, 7, 32'd104857600, 32'd104857600, 32'hFFFFFFFF,
              32'h80000000, 0, 24'hFFFFFF);
    send_word(vps_pkg::OP_LOAD, 8, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
              16'hFFFF, 24'h000000);
    send_word(vps_pkg::OP_LOAD, 9, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
              16'h0001, 24'hFFFFFF);
    send_word(vps_pkg::OP_LOAD, 8'hFF, $urandom, $urandom, $urandom, $urandom, 16'hFFFF,
              24'hFFFFFF);
    send_word(vps_pkg::OP_READ, 8'hFF);
    send_word(vps_pkg::OP_NONE, 8'hAA);
    send_word(vps_pkg::OP_STEP, 0);
    write_reg(vps_pkg::REG_COUNT, 10);
    send_word(vps_pkg::OP_STEP, 3);
    for (int s = 0; s < 10; s++) send_word(vps_pkg::OP_READ, s);
    drain();
  endtask

  task automatic test_random();
    int pick;
    int active;
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 48 : 23) : 0;
      recv_stall_pct = (ph == 2) ? 48 : ((ph == 3) ? 23 : 0);
      active = $urandom_range(2, 9);
      for (int s = 0; s < active; s++) load_near(s);
      write_reg(vps_pkg::REG_COUNT, active);
      write_reg(vps_pkg::REG_DAMPING,
                (ph == 0) ? 0 : ((ph == 1) ? 65535 : $urandom_range(65535)));
      write_reg(vps_pkg::REG_GRAVITY, (ph == 2) ? 65535 : $urandom_range(2000));
      write_reg(vps_pkg::REG_PUSH_GAIN,
                (ph == 3) ? 0 : ((ph == 1) ? 65535 : $urandom_range(65535)));
      write_reg(vps_pkg::REG_BOUND_LOW_X,
                (ph == 2) ? 32'h80000000 : $urandom_range(100000000));
      write_reg(vps_pkg::REG_BOUND_LOW_Y,
                (ph == 2) ? 32'h80000000 : $urandom_range(100000000));
      write_reg(vps_pkg::REG_BOUND_HIGH_X,
                (ph == 2) ? 32'h7FFFFFFF : 32'd104857600 + $urandom_range(3000000));
      write_reg(vps_pkg::REG_BOUND_HIGH_Y,
                (ph == 2) ? 32'h7FFFFFFF : 32'd104857600 + $urandom_range(3000000));
      for (int k = 0; k < 15; k++) begin
        pick = $urandom_range(99);
        if (pick < 30) load_near($urandom_range(active - 1));
        else if (pick < 60) send_word(vps_pkg::OP_READ, $urandom_range(active - 1));
        else if (pick < 85) send_word(vps_pkg::OP_STEP, $urandom);
        else if (pick < 92) send_word(vps_pkg::OP_NONE, $urandom);
        else begin
          // a far-off slot outside the stepped range, fully random
          send_word(vps_pkg::OP_LOAD, $urandom_range(16, 255), $urandom, $urandom,
                    $urandom, $urandom, $urandom_range(65535), $urandom_range(16777215));
        end
      end
      drain();
    end
  endtask

  initial begin
    lo_x = 0; lo_y = 0; hi_x = 64'sd838860800; hi_y = 64'sd629145600;
    count_reg = 0; damp_reg = 65470; grav_reg = 52; gain_reg = 26214;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    drain();
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("PASS verlet_particle_collision_step_top");
    end else begin
      $display("FAIL verlet_particle_collision_step_top");
    end
    $finish;
  end

  initial begin
    #80000000;
    $display("FAIL verlet_particle_collision_step_top");
    $finish;
  end

endmodule

@@ files.f @@
hdl/vps_pkg.sv
hdl/vps_mem.sv
hdl/vps_sqrt.sv
hdl/vps_divider.sv
hdl/verlet_particle_collision_step_top.sv
test/testbench.sv
